>>> rtl/prefixed_integer_text_parser_defines.svh
// Assertion macros for the prefixed integer text parser.
`ifndef PREFIXED_INTEGER_TEXT_PARSER_DEFINES_SVH
`define PREFIXED_INTEGER_TEXT_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define PITP_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pitp assertion failed");
`define PITP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pitp assertion failed");
`else
`define PITP_ASSERT_SAME(name, clk, rst, ante, cons)
`define PITP_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

>>> rtl/pitp_pkg.sv
package pitp_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [3:0] DIGIT_TEN = 4'd10;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;
  localparam logic [1:0] RADIX_BIN = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic       first;
    logic       is_zero;
    logic       is_x;
    logic       is_b;
    logic       ok_dec;
    logic       ok_oct;
    logic       ok_hex;
    logic       ok_bin;
    logic [3:0] digit;
  } token_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

>>> rtl/pitp_front.sv
module pitp_front (
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // ch
  input  logic                   s_axis_tuser,  // first
  input  pitp_pkg::queue_status_t q_status,
  output logic                   push,
  output pitp_pkg::token_t       token
);
  import pitp_pkg::*;

  logic       is_num;
  logic       is_lo_hex;
  logic       is_up_hex;
  logic [7:0] ch;

  assign ch = s_axis_tdata;
  assign s_axis_tready = !q_status.full;
  assign push = s_axis_tvalid && !q_status.full;

  always_comb begin
    is_num    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_lo_hex = (ch >= CH_LO_A) && (ch <= CH_LO_F);
    is_up_hex = (ch >= CH_UP_A) && (ch <= CH_UP_F);
    token.first   = s_axis_tuser;
    token.is_zero = (ch == CH_ZERO);
    token.is_x    = (ch == CH_LO_X);
    token.is_b    = (ch == CH_LO_B);
    token.ok_dec  = is_num;
    token.ok_oct  = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
    token.ok_hex  = is_num || is_lo_hex || is_up_hex;
    token.ok_bin  = (ch == CH_ZERO) || (ch == CH_ONE);
    if (is_lo_hex) begin
      token.digit = 4'(ch - CH_LO_A) + DIGIT_TEN;
    end else if (is_up_hex) begin
      token.digit = 4'(ch - CH_UP_A) + DIGIT_TEN;
    end else begin
      token.digit = 4'(ch - CH_ZERO);
    end
  end

endmodule

>>> rtl/pitp_queue.sv
module pitp_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  pitp_pkg::token_t        push_token,
  input  logic                    pop,
  output pitp_pkg::token_t        pop_token,
  output pitp_pkg::queue_status_t q_status
);
  import pitp_pkg::*;

  token_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_token      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/pitp_back.sv
module pitp_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pitp_pkg::token_t        token,
  input  pitp_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [39:0]             m_axis_tdata  // value[31:0], radix[33:32], zero pad
);
  import pitp_pkg::*;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_ZERO,
    PH_DEC,
    PH_OCT,
    PH_HEX,
    PH_BIN
  } phase_t;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] acc_next;
  logic [VALUE_WIDTH-1:0] acc_base;
  logic [VALUE_WIDTH-1:0] digit_ext;
  logic                   ok;
  logic [1:0]             mode_radix;
  logic                   emit;
  logic [1:0]             emit_radix;
  logic [31:0]            emit_value;
  logic [31:0]            out_value;
  logic [1:0]             out_radix;

  assign pop       = !q_status.empty && (!m_axis_tvalid || m_axis_tready);
  assign digit_ext = VALUE_WIDTH'(token.digit);
  assign m_axis_tdata = {6'd0, out_radix, out_value};

  always_comb begin
    acc_base   = '0;
    ok         = 1'b0;
    mode_radix = RADIX_DEC;
    unique case (phase)
      PH_DEC: begin
        acc_base   = (acc << 3) + (acc << 1);
        ok         = token.ok_dec;
        mode_radix = RADIX_DEC;
      end
      PH_ZERO, PH_OCT: begin
        acc_base   = acc << 3;
        ok         = token.ok_oct;
        mode_radix = RADIX_OCT;
      end
      PH_HEX: begin
        acc_base   = acc << 4;
        ok         = token.ok_hex;
        mode_radix = RADIX_HEX;
      end
      PH_BIN: begin
        acc_base   = acc << 1;
        ok         = token.ok_bin;
        mode_radix = RADIX_BIN;
      end
      default: begin
        acc_base   = '0;
        ok         = 1'b0;
        mode_radix = RADIX_DEC;
      end
    endcase

    phase_next = phase;
    acc_next   = acc;
    emit       = 1'b0;
    emit_radix = mode_radix;
    emit_value = 32'(acc);
    if (token.first) begin
      if (token.is_zero) begin
        phase_next = PH_ZERO;
        acc_next   = '0;
      end else if (token.ok_dec) begin
        phase_next = PH_DEC;
        acc_next   = digit_ext;
      end else begin
        phase_next = PH_DONE;
        acc_next   = '0;
        emit       = 1'b1;
        emit_radix = RADIX_DEC;
        emit_value = '0;
      end
    end else if (phase == PH_DONE) begin
      phase_next = PH_DONE;
    end else if (phase == PH_ZERO && token.is_x) begin
      phase_next = PH_HEX;
    end else if (phase == PH_ZERO && token.is_b) begin
      phase_next = PH_BIN;
    end else if (ok) begin
      phase_next = (phase == PH_ZERO) ? PH_OCT : phase;
      acc_next   = acc_base + digit_ext;
    end else begin
      phase_next = PH_DONE;
      emit       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DONE;
      acc           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        phase         <= phase_next;
        acc           <= acc_next;
        m_axis_tvalid <= emit;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_value <= emit_value;
      out_radix <= emit_radix;
    end
  end

endmodule

>>> rtl/prefixed_integer_text_parser.sv
// Bytes are registered in the queue; a popped byte's result is then registered on m_axis.
// Throughput: one byte per cycle while the queue is not full; the phase and shift-add accumulator step once per byte.
// A four-entry queue between the classifier and the accumulator absorbs output stalls.
// Reset (rst, synchronous, active high) empties the queue, clears the accumulator,
// drops any pending result and leaves the parser waiting for a first byte.
`include "prefixed_integer_text_parser_defines.svh"

module prefixed_integer_text_parser #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch[7:0]
  input  logic        s_axis_tuser,   // first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // value[31:0], radix[33:32], zero pad
);
  import pitp_pkg::*;

  token_t        in_token;
  token_t        q_token;
  queue_status_t q_status;
  logic          push;
  logic          pop;

  pitp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_status      (q_status),
    .push          (push),
    .token         (in_token)
  );

  pitp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (in_token),
    .pop        (pop),
    .pop_token  (q_token),
    .q_status   (q_status)
  );

  pitp_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .token         (q_token),
    .q_status      (q_status),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `PITP_ASSERT_SAME(a_pop_nonempty, clk, rst, pop, !q_status.empty)
  `PITP_ASSERT_SAME(a_no_pop_on_stall, clk, rst, m_axis_tvalid && !m_axis_tready, !pop)
  `PITP_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !m_axis_tvalid && q_status.empty)

endmodule

>>> verif/tb_prefixed_integer_text_parser.sv
`timescale 1ns / 1ps

module tb_prefixed_integer_text_parser;
  import pitp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD_ZERO,
    PH_DEC,
    PH_OCT,
    PH_HEX,
    PH_BIN
  } parse_phase_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  radix;
  } number_t;

  class number_scoreboard;
    parse_phase_t phase;
    logic [31:0]  acc;
    number_t      numbers_q[$];
    int           errors;

    function new();
      phase  = PH_IDLE;
      acc    = '0;
      errors = 0;
    endfunction

    static function int digit_value(logic [7:0] ch, int base);
      int d;
      d = -1;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        d = int'(ch) - int'(CH_ZERO);
      end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
        d = int'(ch) - int'(CH_LO_A) + 10;
      end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
        d = int'(ch) - int'(CH_UP_A) + 10;
      end
      if (d >= base) begin
        d = -1;
      end
      return d;
    endfunction

    function void flag(string msg);
      if (errors < 10) begin
        $display("%0t: %s", $realtime, msg);
      end
      errors++;
    endfunction

    function void take_digit(logic [7:0] ch, int base, logic [1:0] radix);
      int d;
      d = digit_value(ch, base);
      if (d < 0) begin
        numbers_q.push_back('{value: acc, radix: radix});
        phase = PH_IDLE;
      end else begin
        acc = acc * 32'(base) + 32'(d);
      end
    endfunction

    function void note_byte(logic [7:0] ch, logic first);
      if (first) begin
        acc = '0;
        if (ch == CH_ZERO) begin
          phase = PH_LEAD_ZERO;
        end else begin
          phase = PH_DEC;
          take_digit(ch, 10, RADIX_DEC);
        end
        return;
      end
      case (phase)
        PH_LEAD_ZERO: begin
          if (ch == CH_LO_X) begin
            phase = PH_HEX;
          end else if (ch == CH_LO_B) begin
            phase = PH_BIN;
          end else begin
            phase = PH_OCT;
            take_digit(ch, 8, RADIX_OCT);
          end
        end
        PH_DEC: take_digit(ch, 10, RADIX_DEC);
        PH_OCT: take_digit(ch, 8, RADIX_OCT);
        PH_HEX: take_digit(ch, 16, RADIX_HEX);
        PH_BIN: take_digit(ch, 2, RADIX_BIN);
        default: phase = PH_IDLE;
      endcase
    endfunction

    function void check_number(logic [31:0] value, logic [1:0] radix);
      number_t want;
      if (numbers_q.size() == 0) begin
        flag($sformatf("unexpected result value=%h radix=%0d", value, radix));
        return;
      end
      want = numbers_q.pop_front();
      if (value !== want.value || radix !== want.radix) begin
        flag($sformatf("mismatch: expected value=%h radix=%0d, got value=%h radix=%0d",
                       want.value, want.radix, value, radix));
      end
    endfunction

    function int pending();
      return numbers_q.size();
    endfunction

    function void close_out();
      if (numbers_q.size() != 0) begin
        flag($sformatf("%0d expected results never arrived", numbers_q.size()));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;

  number_scoreboard sb = new();

  prefixed_integer_text_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_byte(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_number(m_axis_tdata[31:0], m_axis_tdata[33:32]);
      end
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= first;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_text(input string body, input logic [7:0] tail);
    for (int i = 0; i < body.len(); i++) begin
      send_byte(body[i], i == 0);
    end
    send_byte(tail, 1'b0);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] digit_char(int base);
    int d;
    d = $urandom_range(base - 1);
    if (d < 10) begin
      return CH_ZERO + 8'(d);
    end
    return ($urandom_range(1) ? CH_LO_A : CH_UP_A) + 8'(d - 10);
  endfunction

  task automatic send_random_number();
    int          kind;
    int          base;
    int          n;
    logic [7:0]  t;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    case ($urandom_range(3))
      0: base = 10;
      1: base = 8;
      2: base = 16;
      default: base = 2;
    endcase
    n = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    if (base == 10) begin
      send_byte(CH_ONE + 8'($urandom_range(8)), 1'b1);
    end else begin
      send_byte(CH_ZERO, 1'b1);
      if (base == 16) begin
        send_byte(CH_LO_X, 1'b0);
      end else if (base == 2) begin
        send_byte(CH_LO_B, 1'b0);
      end
    end
    repeat (n) send_byte(digit_char(base), 1'b0);
    // leave the number open now and then so the next start drops it
    if (kind < 70) begin
      if ($urandom_range(3) == 0) begin
        t = 8'h00;
      end else begin
        do t = 8'($urandom_range(255));
        while (number_scoreboard::digit_value(t, base) >= 0);
      end
      send_byte(t, 1'b0);
    end
  endtask

  initial begin
    int target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(CH_SEVEN, 1'b0);
    send_text("0xfA", 8'h00);
    send_text("0b10", "2");
    send_text("07", "8");
    send_text("0", "X");
    send_text("0", 8'h00);
    send_text("0x", "g");
    send_byte("z", 1'b1);
    send_byte(CH_NINE, 1'b1);
    send_text("12", 8'hFF);
    drain_results();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = items_sent + 370;
      while (items_sent < target) begin
        send_random_number();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pitp_pkg.sv
rtl/pitp_front.sv
rtl/pitp_queue.sv
rtl/pitp_back.sv
rtl/prefixed_integer_text_parser.sv
verif/tb_prefixed_integer_text_parser.sv
